/* design/tad_pkg.sv */
package tad_pkg;

   localparam int TDC_BITS        = 12;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;

   localparam int SQRT_STEPS   = 21;
   localparam int CORDIC_STEPS = 31;
   localparam int CW           = 45;
   localparam int ZW           = 35;
   localparam int ZEN_W        = 17;
   localparam int AZ_W         = 19;
   localparam int TH_W         = 14;

   localparam longint Q30_HALF_PI = 64'd1686629713;
   localparam longint Q30_PI      = 64'd3373259426;
   localparam longint Q30_TWO_PI  = 64'd6746518852;
   localparam longint TWO_PI_OUT  =
      (Q30_TWO_PI + (64'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_UNPHYS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_OFFSET_CH2 = 3'd0,
      CSR_OFFSET_CH3 = 3'd1,
      CSR_OFFSET_CH4 = 3'd2,
      CSR_OFFSET_CH5 = 3'd3,
      CSR_LIMIT      = 3'd4,
      CSR_GAIN_X     = 3'd5,
      CSR_GAIN_Y     = 3'd6
   } csr_index_type;

   typedef struct packed {
      status_type             status;
      logic                   neg_a;
      logic                   neg_b;
      logic signed [TH_W-1:0] th;
      logic [19:0]            pa;
      logic [19:0]            pb;
   } side_type;

   typedef struct packed {
      logic [41:0] v;
      logic [41:0] res;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_type;

   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] r;
      case (idx)
         0: r = 30'd843314857;
         1: r = 30'd497837829;
         2: r = 30'd263043837;
         3: r = 30'd133525159;
         4: r = 30'd67021687;
         5: r = 30'd33543516;
         6: r = 30'd16775851;
         7: r = 30'd8388437;
         8: r = 30'd4194283;
         9: r = 30'd2097149;
         default: r = (idx < 31) ? (30'd1 << (30 - idx)) : 30'd0;
      endcase
      return r;
   endfunction

endpackage

/* design/tdc_arrival_direction.sv */
// Channel | Dir | Beat contents (lowest bits first)
// req     | in  | tdata: count_ch1..count_ch5, 12 bits each
// rsp     | out | tuser: status; tdata: zenith, azimuth, thickness
// csr     | in  | write enable, register index, 16-bit data
//
// One event enters per clock unless a stall on rsp holds it; the 21-step
// square-root chain and the 31-step CORDIC chain take one step per register stage.
// Reset (synchronous) clears the valid bits and loads the default registers.
// A stall on rsp freezes every stage together; nothing is lost or repeated.
module tdc_arrival_direction
   import tad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // count_ch1, count_ch2, ..., count_ch5
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // zenith, azimuth, thickness
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [9:0]  off2_ff, off3_ff, off4_ff, off5_ff;
   logic [11:0] limit_ff;
   logic [15:0] gain_x_ff, gain_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off2_ff   <= 10'd31;
         off3_ff   <= 10'd16;
         off4_ff   <= 10'd15;
         off5_ff   <= 10'd11;
         limit_ff  <= 12'd1000;
         gain_x_ff <= 16'd3321;
         gain_y_ff <= 16'd3140;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET_CH2: off2_ff   <= csr_wdata[9:0];
            CSR_OFFSET_CH3: off3_ff   <= csr_wdata[9:0];
            CSR_OFFSET_CH4: off4_ff   <= csr_wdata[9:0];
            CSR_OFFSET_CH5: off5_ff   <= csr_wdata[9:0];
            CSR_LIMIT:      limit_ff  <= csr_wdata[11:0];
            CSR_GAIN_X:     gain_x_ff <= csr_wdata;
            CSR_GAIN_Y:     gain_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: every stage moves unless the output beat is stuck
   logic adv;
   logic out_vld_ff;
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: capture counts
   logic                v0_ff;
   logic [TDC_BITS-1:0] c_ff [5];

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 5; k++) c_ff[k] <= req_tdata[k*12 +: TDC_BITS];
      end
   end

   // ---------------- stage 1: range check, offsets, differences, thickness
   logic               oor;
   logic signed [13:0] t2, t3, t4, t5;
   logic signed [15:0] d24, d35, s_sum, d_dif, th_full;
   logic [14:0]        abs_s, abs_d;
   logic signed [TH_W-1:0] th_sat;

   always_comb begin
      oor = 1'b0;
      for (int k = 0; k < 5; k++) if (12'(c_ff[k]) > limit_ff) oor = 1'b1;
      t2      = $signed({2'b00, c_ff[1]}) - $signed({4'b0000, off2_ff});
      t3      = $signed({2'b00, c_ff[2]}) - $signed({4'b0000, off3_ff});
      t4      = $signed({2'b00, c_ff[3]}) - $signed({4'b0000, off4_ff});
      t5      = $signed({2'b00, c_ff[4]}) - $signed({4'b0000, off5_ff});
      d24     = 16'(t2) - 16'(t4);
      d35     = 16'(t3) - 16'(t5);
      s_sum   = d24 + d35;
      d_dif   = d24 - d35;
      abs_s   = s_sum[15] ? 15'(-s_sum) : s_sum[14:0];
      abs_d   = d_dif[15] ? 15'(-d_dif) : d_dif[14:0];
      th_full = 16'(t2) - 16'(t3) - 16'(t5) + 16'(t4);
      if (th_full > 16'sd8191)       th_sat = 14'sd8191;
      else if (th_full < -16'sd8192) th_sat = -14'sd8192;
      else                           th_sat = th_full[TH_W-1:0];
   end

   logic                   v1_ff, oor1_ff, sgn_s1_ff, sgn_d1_ff;
   logic [14:0]            abs_s1_ff, abs_d1_ff;
   logic signed [TH_W-1:0] th1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v0_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor1_ff   <= oor;
         sgn_s1_ff <= s_sum[15];
         sgn_d1_ff <= d_dif[15];
         abs_s1_ff <= abs_s;
         abs_d1_ff <= abs_d;
         th1_ff    <= th_sat;
      end
   end

   // ---------------- stage 2: gains
   logic                   v2_ff, oor2_ff, sgn_s2_ff, sgn_d2_ff;
   logic [30:0]            pa2_ff, pb2_ff;
   logic signed [TH_W-1:0] th2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pa2_ff    <= gain_x_ff * abs_s1_ff;
         pb2_ff    <= gain_y_ff * abs_d1_ff;
         oor2_ff   <= oor1_ff;
         sgn_s2_ff <= sgn_s1_ff;
         sgn_d2_ff <= sgn_d1_ff;
         th2_ff    <= th1_ff;
      end
   end

   // ---------------- stage 3: bound check on A and B, squares
   logic     v3_ff;
   side_type side3_ff;
   logic [39:0] sqa3_ff, sqb3_ff;
   side_type side3_in;

   always_comb begin
      side3_in.th    = th2_ff;
      side3_in.pa    = pa2_ff[19:0];
      side3_in.pb    = pb2_ff[19:0];
      side3_in.neg_a = sgn_s2_ff && (pa2_ff != 31'd0);
      side3_in.neg_b = sgn_d2_ff && (pb2_ff != 31'd0);
      if (oor2_ff) side3_in.status = STATUS_RANGE;
      else if (pa2_ff[30:20] != 11'd0 || pb2_ff[30:20] != 11'd0)
         side3_in.status = STATUS_UNPHYS;
      else side3_in.status = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side3_in;
         sqa3_ff  <= pa2_ff[19:0] * pa2_ff[19:0];
         sqb3_ff  <= pb2_ff[19:0] * pb2_ff[19:0];
      end
   end

   // ---------------- stage 4: q and 1-q, start of square roots
   logic [40:0] q_sum;
   side_type    side4_in;

   always_comb begin
      q_sum    = {1'b0, sqa3_ff} + {1'b0, sqb3_ff};
      side4_in = side3_ff;
      if (side3_ff.status == STATUS_OK && q_sum[40]) side4_in.status = STATUS_UNPHYS;
   end

   logic     vsq_ff   [SQRT_STEPS+1];
   side_type sidesq_ff[SQRT_STEPS+1];
   sqrt_type sn_ff    [SQRT_STEPS+1];
   sqrt_type cs_ff    [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) vsq_ff[0] <= 1'b0;
      else if (adv) vsq_ff[0] <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sidesq_ff[0] <= side4_in;
         sn_ff[0].v   <= {1'b0, q_sum};
         sn_ff[0].res <= 42'd0;
         cs_ff[0].v   <= (42'd1 << 40) - {1'b0, q_sum};
         cs_ff[0].res <= 42'd0;
      end
   end

   // square-root chain: one result bit per stage, both lanes side by side
   function automatic sqrt_type sqrt_step(input sqrt_type a, input int k);
      sqrt_type    r;
      logic [41:0] bitv;
      logic [41:0] trial;
      bitv  = 42'd1 << (2 * k);
      trial = a.res + bitv;
      if (a.v >= trial) begin
         r.v   = a.v - trial;
         r.res = (a.res >> 1) + bitv;
      end else begin
         r.v   = a.v;
         r.res = a.res >> 1;
      end
      return r;
   endfunction

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) vsq_ff[j+1] <= 1'b0;
         else if (adv) vsq_ff[j+1] <= vsq_ff[j];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sidesq_ff[j+1] <= sidesq_ff[j];
            sn_ff[j+1]     <= sqrt_step(sn_ff[j], SQRT_STEPS - 1 - j);
            cs_ff[j+1]     <= sqrt_step(cs_ff[j], SQRT_STEPS - 1 - j);
         end
      end
   end

   // ---------------- CORDIC: zenith lane (cos, sin), azimuth lane (A, B)
   logic       vco_ff   [CORDIC_STEPS+1];
   side_type   sideco_ff[CORDIC_STEPS+1];
   cordic_type zen_ff   [CORDIC_STEPS+1];
   cordic_type az_ff    [CORDIC_STEPS+1];

   function automatic cordic_type cordic_init(input logic [20:0] xu,
                                              input logic [20:0] yu);
      cordic_type r;
      r.x    = $signed({4'b0000, xu, 20'd0});
      r.y    = $signed({4'b0000, yu, 20'd0});
      r.z    = '0;
      r.zero = (xu == 21'd0) && (yu == 21'd0);
      return r;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type a, input int i);
      cordic_type           r;
      logic signed [CW-1:0] xs, ys, ny;
      logic signed [ZW-1:0] ang;
      xs  = a.x >>> i;
      ny  = -a.y;
      ys  = a.y[CW-1] ? -(ny >>> i) : (a.y >>> i);
      ang = $signed({{(ZW-30){1'b0}}, atan_q30(i)});
      r   = a;
      if (!a.y[CW-1]) begin
         r.x = a.x + ys;
         r.y = a.y - xs;
         r.z = a.z + ang;
      end else begin
         r.x = a.x - ys;
         r.y = a.y + xs;
         r.z = a.z - ang;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) vco_ff[0] <= 1'b0;
      else if (adv) vco_ff[0] <= vsq_ff[SQRT_STEPS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sideco_ff[0] <= sidesq_ff[SQRT_STEPS];
         zen_ff[0]    <= cordic_init(cs_ff[SQRT_STEPS].res[20:0],
                                     sn_ff[SQRT_STEPS].res[20:0]);
         az_ff[0]     <= cordic_init({1'b0, sidesq_ff[SQRT_STEPS].pa},
                                     {1'b0, sidesq_ff[SQRT_STEPS].pb});
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) vco_ff[i+1] <= 1'b0;
         else if (adv) vco_ff[i+1] <= vco_ff[i];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sideco_ff[i+1] <= sideco_ff[i];
            zen_ff[i+1]    <= cordic_step(zen_ff[i], i);
            az_ff[i+1]     <= cordic_step(az_ff[i], i);
         end
      end
   end

   // ---------------- final stage: clamp, fold into quadrant, round, wrap
   function automatic logic signed [ZW-1:0] clamp_angle(input cordic_type a);
      logic signed [ZW-1:0] z;
      if (a.zero || a.z < 0)                     z = '0;
      else if (a.z > ZW'(Q30_HALF_PI))           z = ZW'(Q30_HALF_PI);
      else                                       z = a.z;
      return z;
   endfunction

   side_type             sf;
   logic signed [ZW-1:0] zen_a, az_a, phi, zen_r, az_r;
   logic [ZEN_W-1:0]     zen_out;
   logic [AZ_W-1:0]      az_out;
   logic signed [TH_W-1:0] th_out;

   always_comb begin
      sf    = sideco_ff[CORDIC_STEPS];
      zen_a = clamp_angle(zen_ff[CORDIC_STEPS]);
      az_a  = clamp_angle(az_ff[CORDIC_STEPS]);
      case ({sf.neg_a, sf.neg_b})
         2'b00:   phi = az_a;
         2'b10:   phi = ZW'(Q30_PI) - az_a;
         2'b11:   phi = ZW'(Q30_PI) + az_a;
         default: phi = ZW'(Q30_TWO_PI) - az_a;
      endcase
      zen_r = (zen_a + ZW'(64'd1 << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      az_r  = (phi + ZW'(64'd1 << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      if (az_r >= ZW'(TWO_PI_OUT)) az_r = '0;
      zen_out = zen_r[ZEN_W-1:0];
      az_out  = az_r[AZ_W-1:0];
      th_out  = sf.th;
      if (sf.status != STATUS_OK) begin
         zen_out = '0;
         az_out  = '0;
         th_out  = '0;
      end
   end

   logic [55:0] out_data_ff;
   logic [1:0]  out_user_ff;

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= vco_ff[CORDIC_STEPS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {6'd0, th_out, az_out, zen_out};
         out_user_ff <= sf.status;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

/* design/tad_checker.sv */
module tad_checker
   import tad_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // input side is ready exactly when the output beat can move
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output backpressure");

   // a rejected event carries all-zero result fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == 56'd0)
      else $error("rejected event with nonzero fields");

   // accepted angles stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OK |->
         rsp_tdata[16:0] <= 17'd102944 && rsp_tdata[35:17] < 19'(TWO_PI_OUT))
      else $error("angle out of range");

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind tdc_arrival_direction tad_checker u_tad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
